// ===== src/hpa_pkg.sv =====
package hpa_pkg;

  localparam int MODE_W   = 2;
  localparam int HANDLE_W = 8;
  localparam int STATUS_W = 2;

  localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TRY    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FREE   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE_FREE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_IN_USE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = 2'd3;

  // free queue controls
  typedef struct packed {
    logic rd;
    logic pop;
    logic push;
  } fq_ctl_t;

  // used-map controls
  typedef struct packed {
    logic rd;
    logic wr;
    logic wr_bit;
  } um_ctl_t;

endpackage

// ===== src/hpa_free_queue.sv =====
module hpa_free_queue #(
  parameter int DEPTH = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hpa_pkg::fq_ctl_t             ctl_i,
  input  logic [$clog2(DEPTH)-1:0]     push_data_i,
  output logic [$clog2(DEPTH)-1:0]     rd_data_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [AW-1:0] mem [DEPTH];
  logic [AW-1:0] rd_data_q;
  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (ctl_i.pop) begin
      head_d  = (head_q == LAST) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end
    if (ctl_i.push) begin
      tail_d  = (tail_q == LAST) ? '0 : tail_q + 1'b1;
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem[tail_q] <= push_data_i;
    end
    if (ctl_i.rd) begin
      rd_data_q <= mem[head_q];
    end
  end

  assign rd_data_o = rd_data_q;
  assign count_o   = count_q;

endmodule

// ===== src/hpa_used_map.sv =====
module hpa_used_map #(
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  hpa_pkg::um_ctl_t         ctl_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  output logic                     rd_bit_o
);

  logic mem [DEPTH];
  logic rd_bit_q;

  // no reset: entries at or above the fresh count are treated as clear
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem[wr_addr_i] <= ctl_i.wr_bit;
    end
    if (ctl_i.rd) begin
      rd_bit_q <= mem[rd_addr_i];
    end
  end

  assign rd_bit_o = rd_bit_q;

endmodule

// ===== src/handle_pool_allocator_top.sv =====
// Handle pool allocator: FIFO free queue and used map in synchronous RAMs.
// The result strobe is registered: an accepted start sets the exec state, and
// the exec state sets res_valid_o. The RAM read is issued as start is taken and
// the read-modify-write follows while busy, which holds off the next request.
// Reset clears pointers, counts and the fresh-handle counter; the used map needs
// no clearing pass, so requests are taken right after reset. Results cannot stall.
module handle_pool_allocator_top #(
  parameter int POOL_SIZE = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [hpa_pkg::MODE_W-1:0]    mode_i,
  input  logic [hpa_pkg::HANDLE_W-1:0]  handle_i,
  output logic                          res_valid_o,
  output logic [hpa_pkg::HANDLE_W-1:0]  handle_res_o,
  output logic [hpa_pkg::STATUS_W-1:0]  status_o
);

  // only handles below 256 can ever be released, so queue and map need no more
  localparam int QD = (POOL_SIZE < 256) ? POOL_SIZE : 256;
  localparam int QA = $clog2(QD);
  localparam int CW = $clog2(QD + 1);
  localparam int NW = $clog2(POOL_SIZE + 1);
  localparam int RW = (NW > hpa_pkg::HANDLE_W) ? NW : hpa_pkg::HANDLE_W;
  localparam logic [hpa_pkg::HANDLE_W:0] QD_L   = (hpa_pkg::HANDLE_W + 1)'(QD);
  localparam logic [NW-1:0]              POOL_L = NW'(POOL_SIZE);
  localparam logic [RW-1:0]              QD_R   = RW'(QD);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic accept;

  logic [hpa_pkg::MODE_W-1:0]   mode_q;
  logic [hpa_pkg::HANDLE_W-1:0] req_q;
  logic                         in_rng_q;
  logic [NW-1:0]                created_q, created_d;

  logic                          valid_q, valid_d;
  logic [hpa_pkg::HANDLE_W-1:0]  res_q, res_d;
  logic [hpa_pkg::STATUS_W-1:0]  status_q, status_d;

  hpa_pkg::fq_ctl_t fq_ctl;
  hpa_pkg::um_ctl_t um_ctl;
  logic [QA-1:0]    fq_rd_data;
  logic [CW-1:0]    fq_count;
  logic             um_rd_bit;
  logic [QA-1:0]    um_wr_addr;

  logic [RW-1:0]    created_w;
  logic             held;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q == ST_EXEC);

  assign created_w = RW'(created_q);
  // map bits at or above the fresh count were never written and read as clear
  assign held = in_rng_q && (RW'(req_q) < created_w) && um_rd_bit;

  always_comb begin
    state_d     = accept ? ST_EXEC : ST_IDLE;
    created_d   = created_q;
    valid_d     = 1'b0;
    res_d       = '0;
    status_d    = hpa_pkg::ST_OK;
    fq_ctl.rd   = accept;
    fq_ctl.pop  = 1'b0;
    fq_ctl.push = 1'b0;
    um_ctl.rd     = accept;
    um_ctl.wr     = 1'b0;
    um_ctl.wr_bit = 1'b0;
    um_wr_addr    = req_q[QA-1:0];
    if (state_q == ST_EXEC) begin
      valid_d = 1'b1;
      unique case (mode_q)
        hpa_pkg::MODE_ALLOC, hpa_pkg::MODE_TRY: begin
          priority if (fq_count != '0) begin
            fq_ctl.pop    = 1'b1;
            res_d         = hpa_pkg::HANDLE_W'(fq_rd_data);
            um_ctl.wr     = 1'b1;
            um_ctl.wr_bit = 1'b1;
            um_wr_addr    = fq_rd_data;
          end else if (mode_q == hpa_pkg::MODE_TRY) begin
            status_d = hpa_pkg::ST_NONE_FREE;
          end else if (created_q < POOL_L) begin
            res_d         = created_w[hpa_pkg::HANDLE_W-1:0];
            created_d     = created_q + 1'b1;
            um_ctl.wr     = (created_w < QD_R);
            um_ctl.wr_bit = 1'b1;
            um_wr_addr    = created_q[QA-1:0];
          end else begin
            status_d = hpa_pkg::ST_EXHAUSTED;
          end
        end
        hpa_pkg::MODE_FREE: begin
          if (held) begin
            fq_ctl.push   = 1'b1;
            um_ctl.wr     = 1'b1;
            um_ctl.wr_bit = 1'b0;
          end else begin
            status_d = hpa_pkg::ST_NOT_IN_USE;
          end
        end
        hpa_pkg::MODE_UNUSED: begin
          status_d = hpa_pkg::ST_OK;
        end
        default: begin
          status_d = hpa_pkg::ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      created_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      created_q <= created_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q   <= mode_i;
      req_q    <= handle_i;
      in_rng_q <= ({1'b0, handle_i} < QD_L);
    end
    res_q    <= res_d;
    status_q <= status_d;
  end

  hpa_free_queue #(
    .DEPTH(QD)
  ) u_free_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (fq_ctl),
    .push_data_i(req_q[QA-1:0]),
    .rd_data_o  (fq_rd_data),
    .count_o    (fq_count)
  );

  hpa_used_map #(
    .DEPTH(QD)
  ) u_used_map (
    .clk_i    (clk_i),
    .ctl_i    (um_ctl),
    .rd_addr_i(handle_i[QA-1:0]),
    .wr_addr_i(um_wr_addr),
    .rd_bit_o (um_rd_bit)
  );

  assign res_valid_o  = valid_q;
  assign handle_res_o = res_q;
  assign status_o     = status_q;

endmodule

// ===== verif/tb_handle_pool_allocator_top.sv =====
module tb_handle_pool_allocator_top;

  localparam int NUM_HANDLES = 256;
  localparam int RANDOM_ITEMS = 420;

  typedef logic [hpa_pkg::HANDLE_W-1:0] hnd_t;

  typedef struct {
    logic [hpa_pkg::HANDLE_W-1:0] handle;
    logic [hpa_pkg::STATUS_W-1:0] status;
  } reply_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic [hpa_pkg::MODE_W-1:0]   mode_i = hpa_pkg::MODE_UNUSED;
  logic [hpa_pkg::HANDLE_W-1:0] handle_i = '0;
  logic                         res_valid_o;
  logic [hpa_pkg::HANDLE_W-1:0] handle_res_o;
  logic [hpa_pkg::STATUS_W-1:0] status_o;

  handle_pool_allocator_top #(.POOL_SIZE(NUM_HANDLES)) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .mode_i       (mode_i),
    .handle_i     (handle_i),
    .res_valid_o  (res_valid_o),
    .handle_res_o (handle_res_o),
    .status_o     (status_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow copy of the pool
  logic [hpa_pkg::HANDLE_W-1:0] pool_queue [NUM_HANDLES];
  logic [hpa_pkg::HANDLE_W-1:0] pool_head;
  logic [hpa_pkg::HANDLE_W-1:0] pool_tail;
  logic [8:0]                   pool_free_cnt;
  logic [8:0]                   pool_created;
  bit                           pool_in_use [NUM_HANDLES];

  reply_t replies_q[$];

  int items_sent;
  int replies_seen;
  int mismatches;
  int failures;
  int status_hits [4];
  int max_free_cnt;
  int queue_wraps;

  function automatic void pool_clear();
    pool_head = '0;
    pool_tail = '0;
    pool_free_cnt = '0;
    pool_created = '0;
    foreach (pool_in_use[i]) pool_in_use[i] = 1'b0;
  endfunction

  // updates the shadow pool for one beat and returns the reply it should give
  function automatic reply_t pool_predict(input logic [hpa_pkg::MODE_W-1:0] mode,
                                          input logic [hpa_pkg::HANDLE_W-1:0] hnd);
    reply_t r;
    r.handle = '0;
    r.status = hpa_pkg::ST_OK;
    if (mode == hpa_pkg::MODE_ALLOC || mode == hpa_pkg::MODE_TRY) begin
      if (pool_free_cnt != 0) begin
        r.handle = pool_queue[pool_head];
        pool_in_use[r.handle] = 1'b1;
        if (pool_head == NUM_HANDLES - 1) queue_wraps++;
        pool_head = pool_head + 1'b1;
        pool_free_cnt = pool_free_cnt - 1'b1;
      end else if (mode == hpa_pkg::MODE_TRY) begin
        r.status = hpa_pkg::ST_NONE_FREE;
      end else if (pool_created < NUM_HANDLES) begin
        r.handle = pool_created[hpa_pkg::HANDLE_W-1:0];
        pool_in_use[r.handle] = 1'b1;
        pool_created = pool_created + 1'b1;
      end else begin
        r.status = hpa_pkg::ST_EXHAUSTED;
      end
    end else if (mode == hpa_pkg::MODE_FREE) begin
      if (pool_in_use[hnd] && pool_free_cnt < NUM_HANDLES) begin
        pool_queue[pool_tail] = hnd;
        pool_tail = pool_tail + 1'b1;
        pool_free_cnt = pool_free_cnt + 1'b1;
        pool_in_use[hnd] = 1'b0;
        if (pool_free_cnt > max_free_cnt) max_free_cnt = pool_free_cnt;
      end else begin
        r.status = hpa_pkg::ST_NOT_IN_USE;
      end
    end
    status_hits[r.status]++;
    return r;
  endfunction

  // a granted handle, searched from a random point; random if none is granted
  function automatic logic [hpa_pkg::HANDLE_W-1:0] pick_granted();
    int base;
    base = $urandom_range(0, NUM_HANDLES - 1);
    for (int i = 0; i < NUM_HANDLES; i++) begin
      if (pool_in_use[(base + i) % NUM_HANDLES]) return hnd_t'((base + i) % NUM_HANDLES);
    end
    return hnd_t'(base);
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_request(input logic [hpa_pkg::MODE_W-1:0] mode,
                              input logic [hpa_pkg::HANDLE_W-1:0] hnd);
    start <= 1'b1;
    mode_i <= mode;
    handle_i <= hnd;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    replies_q.push_back(pool_predict(mode, hnd));
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic idle(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(negedge clk_i);
    end
  endtask

  task automatic send_gapped(input logic [hpa_pkg::MODE_W-1:0] mode,
                             input logic [hpa_pkg::HANDLE_W-1:0] hnd);
    send_request(mode, hnd);
    idle(gap_len());
  endtask

  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && res_valid_o) begin
      replies_seen++;
      if (replies_q.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected reply handle=%0d status=%0d", handle_res_o, status_o);
      end else begin
        want = replies_q.pop_front();
        if (handle_res_o !== want.handle || status_o !== want.status) begin
          failures++;
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: reply %0d: handle exp %0d got %0d, status exp %0d got %0d",
                     replies_seen, want.handle, handle_res_o, want.status, status_o);
        end
      end
    end
  end

  task automatic test_corner_cases();
    send_gapped(hpa_pkg::MODE_UNUSED, 8'hFF);
    send_gapped(hpa_pkg::MODE_TRY, 8'h00);          // empty queue, nothing fresh issued
    send_gapped(hpa_pkg::MODE_FREE, 8'h00);         // never granted
    send_gapped(hpa_pkg::MODE_FREE, 8'hFF);
    send_gapped(hpa_pkg::MODE_ALLOC, 8'hAA);        // fresh 0
    send_gapped(hpa_pkg::MODE_ALLOC, 8'h55);        // fresh 1
    send_gapped(hpa_pkg::MODE_FREE, 8'h00);
    send_gapped(hpa_pkg::MODE_FREE, 8'h00);         // double release
    send_gapped(hpa_pkg::MODE_TRY, 8'hFF);          // takes 0 back
    send_gapped(hpa_pkg::MODE_TRY, 8'h00);
    send_gapped(hpa_pkg::MODE_ALLOC, 8'h00);        // fresh 2
    send_gapped(hpa_pkg::MODE_FREE, 8'h02);
    send_gapped(hpa_pkg::MODE_FREE, 8'h01);
    send_gapped(hpa_pkg::MODE_ALLOC, 8'h00);        // oldest released first
    send_gapped(hpa_pkg::MODE_ALLOC, 8'h00);
    send_gapped(hpa_pkg::MODE_UNUSED, 8'h00);
    send_gapped(hpa_pkg::MODE_FREE, 8'h80);
    // back to back, busy holds the second beat off
    send_request(hpa_pkg::MODE_ALLOC, 8'h00);
    send_request(hpa_pkg::MODE_FREE, 8'h03);
    send_request(hpa_pkg::MODE_TRY, 8'h00);
    send_request(hpa_pkg::MODE_UNUSED, 8'h7F);
    idle(1);
  endtask

  task automatic test_exhaustion();
    logic [hpa_pkg::HANDLE_W-1:0] order [NUM_HANDLES];
    int j;
    logic [hpa_pkg::HANDLE_W-1:0] tmp;
    while (pool_created < NUM_HANDLES || pool_free_cnt != 0)
      send_gapped(hpa_pkg::MODE_ALLOC, hnd_t'($urandom_range(0, 255)));
    send_gapped(hpa_pkg::MODE_ALLOC, 8'h00);
    send_gapped(hpa_pkg::MODE_ALLOC, 8'hFF);
    send_gapped(hpa_pkg::MODE_TRY, 8'h00);
    send_gapped(hpa_pkg::MODE_FREE, 8'hFF);
    send_gapped(hpa_pkg::MODE_ALLOC, 8'h00);
    // release every handle in shuffled order so the queue fills completely
    foreach (order[i]) order[i] = hnd_t'(i);
    for (int i = NUM_HANDLES - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    foreach (order[i]) send_gapped(hpa_pkg::MODE_FREE, order[i]);
    send_gapped(hpa_pkg::MODE_FREE, order[0]);
    for (int i = 0; i < 40; i++)
      send_gapped(hpa_pkg::MODE_TRY, hnd_t'($urandom_range(0, 255)));
  endtask

  task automatic test_random_traffic();
    int alloc_w;
    bit burst;
    int r;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: alloc_w = 25;
          1: alloc_w = 50;
          default: alloc_w = 80;
        endcase
        burst = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_request(hpa_pkg::MODE_UNUSED, hnd_t'($urandom_range(0, 255)));
      end else if (r < alloc_w) begin
        send_request(($urandom_range(0, 9) < 7) ? hpa_pkg::MODE_ALLOC : hpa_pkg::MODE_TRY,
                     hnd_t'($urandom_range(0, 255)));
      end else begin
        send_request(hpa_pkg::MODE_FREE,
                     ($urandom_range(0, 99) < 85) ? pick_granted()
                                                  : hnd_t'($urandom_range(0, 255)));
      end
      if (!burst) idle(gap_len());
    end
  endtask

  initial begin
    int guard;
    pool_clear();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_corner_cases();
    test_exhaustion();
    test_random_traffic();

    start <= 1'b0;
    guard = 0;
    while (replies_q.size() != 0 && guard < 1000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
    if (replies_q.size() != 0) begin
      failures++;
      $display("ERROR: %0d replies never arrived", replies_q.size());
    end

    $display("Sent %0d beats, checked %0d replies, %0d mismatches.",
             items_sent, replies_seen, mismatches);
    $display("Status mix ok/none/not-in-use/exhausted: %0d/%0d/%0d/%0d, peak queue %0d, wraps %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3],
             max_free_cnt, queue_wraps);
    if (failures == 0)
      $display("tb_handle_pool_allocator_top passed");
    else
      $display("tb_handle_pool_allocator_top failed");
    $finish;
  end

  initial begin
    #3000000;
    $display("ERROR: timeout");
    $display("tb_handle_pool_allocator_top failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/hpa_pkg.sv
src/hpa_free_queue.sv
src/hpa_used_map.sv
src/handle_pool_allocator_top.sv
verif/tb_handle_pool_allocator_top.sv
